### hw/rtl/differential_drive_odometry_defines.svh
// assertion macros shared by the odometry rtl
// no dependencies; included by files that carry assertions
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH

// same-cycle implication
`define DDO_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DDO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/ddo_pkg.sv
// types, constants and helper functions of the odometry block
// no dependencies; imported by every rtl module
`timescale 1ns / 1ps

package ddo_pkg;

   localparam int CORDIC_STEPS    = 16;
   localparam int CELL_COORD_BITS = 8;

   localparam int NUM_W  = 51;
   localparam int SN_W   = 52;
   localparam int DEN_W  = 24;
   localparam int CNT_W  = $clog2(NUM_W);
   localparam int XY_W   = 34;
   localparam int Z_W    = 35;
   localparam int TRIG_W = 20;
   localparam int ANG_W  = 19;
   localparam int ACC_W  = 48;
   localparam int ITER_W = $clog2(CORDIC_STEPS);
   localparam int REQ_W  = 112;
   localparam int RSP_W  = 176;
   localparam int FOLD_W = 30;
   localparam int MODQ_W = 12;
   localparam int MODR_W = 20;

   localparam logic [ANG_W-1:0] TWO_PI_Q16 = 19'd411775;
   localparam logic [ANG_W-1:0] Q16_45     = 19'd51472;
   localparam logic [ANG_W-1:0] Q16_135    = 19'd154416;
   localparam logic [ANG_W-1:0] Q16_225    = 19'd257359;
   localparam logic [ANG_W-1:0] Q16_315    = 19'd360303;

   // byte weights 2^(8i) reduced modulo two pi in q16
   localparam logic [6:0][ANG_W-1:0] MOD_CHUNK = {
      19'((64'd1 << 48) % 64'd411775),
      19'((64'd1 << 40) % 64'd411775),
      19'((64'd1 << 32) % 64'd411775),
      19'((64'd1 << 24) % 64'd411775),
      19'((64'd1 << 16) % 64'd411775),
      19'((64'd1 << 8) % 64'd411775),
      19'(64'd1 % 64'd411775)
   };
   // floor(2^49 / two pi in q16)
   localparam logic [30:0] MOD_RECIP = 31'((64'd1 << 49) / 64'd411775);

   localparam logic signed [Z_W-1:0]  PI_Q30      = 35'sd3373259426;
   localparam logic signed [Z_W-1:0]  TWO_PI_Q30  = 35'sd6746518852;
   localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032874;

   localparam logic signed [SN_W-1:0] S32_MAX  = SN_W'(64'sd2147483647);
   localparam logic signed [SN_W-1:0] S32_MIN  = -S32_MAX - SN_W'(1);
   localparam logic signed [SN_W-1:0] CELL_MAX =
      SN_W'((64'sd1 <<< (CELL_COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [SN_W-1:0] CELL_MIN = -CELL_MAX - SN_W'(1);
   localparam logic signed [ACC_W+1:0] ACC_HI  = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [ACC_W+1:0] ACC_LO  = -ACC_HI - 50'sd1;

   typedef enum logic [1:0] {
      REG_WHEEL_BASE     = 2'd0,
      REG_CELL_WIDTH     = 2'd1,
      REG_TICK_RATE      = 2'd2,
      REG_ROTATION_SCALE = 2'd3
   } reg_type;

   typedef enum logic [1:0] {
      DIR_NORTH = 2'd0,
      DIR_WEST  = 2'd1,
      DIR_SOUTH = 2'd2,
      DIR_EAST  = 2'd3
   } compass_type;

   typedef enum logic [2:0] {
      OP_RATE,
      OP_ANG,
      OP_STEP_X,
      OP_STEP_Y,
      OP_CELL_X,
      OP_CELL_Y
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_MOD_FOLD,
      ST_MOD_MUL,
      ST_MOD_SUB,
      ST_MOD_FIX,
      ST_CORDIC_GO,
      ST_CORDIC_WAIT,
      ST_STEP_MUL,
      ST_ACC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic   load;
      logic   prod;
      logic   div_start;
      logic   div_take;
      op_type op;
      logic   mod_fold;
      logic   mod_mul;
      logic   mod_sub;
      logic   mod_fix;
      logic   cordic_start;
      logic   step_mul;
      logic   acc_upd;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic cordic_done;
   } sts_type;

   function automatic logic [30:0] atan_q30(input logic [4:0] idx);
      logic [30:0] v;
      case (idx)
         5'd0:    v = 31'd843314857;
         5'd1:    v = 31'd497837829;
         5'd2:    v = 31'd263043837;
         5'd3:    v = 31'd133525159;
         5'd4:    v = 31'd67021687;
         5'd5:    v = 31'd33543516;
         5'd6:    v = 31'd16775851;
         5'd7:    v = 31'd8388437;
         5'd8:    v = 31'd4194283;
         5'd9:    v = 31'd2097149;
         5'd10:   v = 31'd1048576;
         5'd11:   v = 31'd524288;
         5'd12:   v = 31'd262144;
         5'd13:   v = 31'd131072;
         5'd14:   v = 31'd65536;
         5'd15:   v = 31'd32768;
         5'd16:   v = 31'd16384;
         5'd17:   v = 31'd8192;
         5'd18:   v = 31'd4096;
         5'd19:   v = 31'd2048;
         5'd20:   v = 31'd1024;
         5'd21:   v = 31'd512;
         5'd22:   v = 31'd256;
         5'd23:   v = 31'd128;
         default: v = 31'd0;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] sat_s32(input logic signed [SN_W-1:0] v);
      logic signed [SN_W-1:0] c;
      if (v > S32_MAX) begin
         c = S32_MAX;
      end else if (v < S32_MIN) begin
         c = S32_MIN;
      end else begin
         c = v;
      end
      return c[31:0];
   endfunction

   function automatic logic [7:0] sat_cell(input logic signed [SN_W-1:0] v);
      logic signed [SN_W-1:0] c;
      if (v > CELL_MAX) begin
         c = CELL_MAX;
      end else if (v < CELL_MIN) begin
         c = CELL_MIN;
      end else begin
         c = v;
      end
      return c[7:0];
   endfunction

endpackage

### hw/rtl/ddo_div.sv
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on ddo_pkg
`timescale 1ns / 1ps

module ddo_div import ddo_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   r_sh;
   logic [DEN_W:0]   r_sub;
   logic             fits;

   always_comb begin
      r_sh  = {r_ff, q_ff[NUM_W-1]};
      fits  = r_sh >= {1'b0, d_ff};
      r_sub = r_sh - {1'b0, d_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         q_in    = num;
         r_in    = '0;
         d_in    = den;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         q_in   = {q_ff[NUM_W-2:0], fits};
         r_in   = fits ? r_sub[DEN_W-1:0] : r_sh[DEN_W-1:0];
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

### hw/rtl/ddo_cordic.sv
// rotation-mode cordic, one iteration per cycle, gives cos and sin in q16
// depends on ddo_pkg
`timescale 1ns / 1ps

module ddo_cordic import ddo_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ANG_W-1:0]         angle,
   output logic                     done,
   output logic signed [TRIG_W-1:0] cos_q16,
   output logic signed [TRIG_W-1:0] sin_q16
);

   localparam logic signed [XY_W-1:0] RND = XY_W'(8192);

   logic signed [XY_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]   z_ff, z_in;
   logic                    neg_ff, neg_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic signed [Z_W-1:0]   z0, z1, z2;
   logic                    n2;
   logic signed [XY_W-1:0]  xs, ys, xf, yf;
   logic signed [Z_W-1:0]   at;

   always_comb begin
      z0 = $signed({2'b00, angle, 14'd0});
      z1 = (z0 > PI_Q30) ? z0 - TWO_PI_Q30 : z0;
      n2 = 1'b0;
      z2 = z1;
      if (z1 > HALF_PI_Q30) begin
         z2 = z1 - PI_Q30;
         n2 = 1'b1;
      end else if (z1 < -HALF_PI_Q30) begin
         z2 = z1 + PI_Q30;
         n2 = 1'b1;
      end
   end

   always_comb begin
      xs = x_ff >>> iter_ff;
      ys = y_ff >>> iter_ff;
      at = $signed(Z_W'(atan_q30(5'(iter_ff))));
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      neg_in  = neg_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         x_in    = GAIN_Q30;
         y_in    = '0;
         z_in    = z2;
         neg_in  = n2;
         iter_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!z_ff[Z_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         iter_in = iter_ff + ITER_W'(1);
         if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      xf      = neg_ff ? -x_ff : x_ff;
      yf      = neg_ff ? -y_ff : y_ff;
      cos_q16 = TRIG_W'((xf + RND) >>> 14);
      sin_q16 = TRIG_W'((yf + RND) >>> 14);
   end

   assign done = done_ff;

endmodule

### hw/rtl/ddo_dp.sv
// odometry datapath: config registers, products, shared divider, cordic,
// accumulators and result register; depends on ddo_pkg, ddo_div, ddo_cordic
`timescale 1ns / 1ps

module ddo_dp import ddo_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic             csr_valid,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data,
   input  logic [REQ_W-1:0] req_tdata,
   output logic [RSP_W-1:0] rsp_tdata
);

   logic [15:0] wb_ff, wb_in, cw_ff, cw_in, sc_ff, sc_in;
   logic [7:0]  tr_ff, tr_in;
   logic [15:0] wb_eff, cw_eff;
   logic [7:0]  tr_eff;

   logic [23:0] ls_ff, rs_ff, fwd_ff;
   logic [31:0] ld_ff, rd_ff;
   logic signed [SN_W-1:0] prate_ff, pang_ff, ang_ff, stepx_ff, stepy_ff;
   logic signed [43:0]     pcx_ff, pcy_ff;
   logic [31:0]            rate_ff;
   logic [ANG_W-1:0]       a_ff;
   logic [7:0]             cellx_ff, celly_ff;
   logic signed [ACC_W-1:0] accx_ff, accx_in, accy_ff, accy_in;
   logic                   neg_ff;
   logic [RSP_W-1:0]       rsp_ff;

   logic signed [24:0] sum_sp, diff_sp;
   logic signed [32:0] diff_d;
   logic signed [17:0] sc_s;
   logic signed [42:0] prate_w;
   logic signed [50:0] pang_w;

   logic signed [SN_W-1:0] n_sel;
   logic [DEN_W-1:0]       d_sel;
   logic [SN_W-1:0]        mag;
   logic [NUM_W-1:0]       div_num;
   logic                   div_done;
   logic [NUM_W-1:0]       div_quo;
   logic signed [SN_W-1:0] q_pos, q_s;

   logic [55:0]        mag_ang;
   logic [FOLD_W-1:0]  fold_w, fold_ff;
   logic [60:0]        recip_w;
   logic [MODQ_W-1:0]  mq_ff;
   logic [FOLD_W-1:0]  mr_w;
   logic [MODR_W-1:0]  mr_ff, mr_fix;

   logic                     cor_done;
   logic signed [TRIG_W-1:0] cos_q16, sin_q16;

   logic signed [ACC_W+1:0] sumx, sumy;
   logic [1:0]              dir;

   // configuration
   always_comb begin
      wb_in = wb_ff;
      cw_in = cw_ff;
      tr_in = tr_ff;
      sc_in = sc_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_WHEEL_BASE:     wb_in = csr_data;
            REG_CELL_WIDTH:     cw_in = csr_data;
            REG_TICK_RATE:      tr_in = csr_data[7:0];
            REG_ROTATION_SCALE: sc_in = csr_data;
            default:            wb_in = wb_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff <= 16'd4096;
         cw_ff <= 16'd7680;
         tr_ff <= 8'd100;
         sc_ff <= 16'd27080;
      end else begin
         wb_ff <= wb_in;
         cw_ff <= cw_in;
         tr_ff <= tr_in;
         sc_ff <= sc_in;
      end
   end

   assign wb_eff = (wb_ff == 16'd0) ? 16'd1 : wb_ff;
   assign cw_eff = (cw_ff == 16'd0) ? 16'd1 : cw_ff;
   assign tr_eff = (tr_ff == 8'd0) ? 8'd1 : tr_ff;

   // products
   always_comb begin
      sum_sp  = $signed({ls_ff[23], ls_ff}) + $signed({rs_ff[23], rs_ff});
      diff_sp = $signed({rs_ff[23], rs_ff}) - $signed({ls_ff[23], ls_ff});
      diff_d  = $signed({rd_ff[31], rd_ff}) - $signed({ld_ff[31], ld_ff});
      sc_s    = $signed({1'b0, sc_ff, 1'b0});
      prate_w = diff_sp * sc_s;
      pang_w  = diff_d * sc_s;
   end

   // divider operand select, rounding half away from zero
   always_comb begin
      n_sel   = pang_ff;
      d_sel   = DEN_W'(wb_eff);
      case (cmd.op)
         OP_RATE:   n_sel = prate_ff;
         OP_ANG:    n_sel = pang_ff;
         OP_STEP_X: begin
            n_sel = SN_W'(pcx_ff);
            d_sel = DEN_W'({tr_eff, 8'd0});
         end
         OP_STEP_Y: begin
            n_sel = SN_W'(pcy_ff);
            d_sel = DEN_W'({tr_eff, 8'd0});
         end
         OP_CELL_X: begin
            n_sel = SN_W'(accx_ff);
            d_sel = {cw_eff, 8'd0};
         end
         OP_CELL_Y: begin
            n_sel = SN_W'(accy_ff);
            d_sel = {cw_eff, 8'd0};
         end
         default:   n_sel = pang_ff;
      endcase
      mag     = n_sel[SN_W-1] ? SN_W'(-n_sel) : SN_W'(n_sel);
      div_num = mag[NUM_W-1:0] + NUM_W'(d_sel >> 1);
   end

   ddo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (d_sel),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      q_pos = $signed({1'b0, div_quo});
      q_s   = neg_ff ? -q_pos : q_pos;
   end

   // heading wrapped to one turn: byte fold, reciprocal quotient, correction
   always_comb begin
      mag_ang = ang_ff[SN_W-1] ? 56'(-ang_ff) : 56'(ang_ff);
      fold_w  = '0;
      for (int i = 0; i < 7; i++) begin
         fold_w = fold_w + FOLD_W'(mag_ang[8*i +: 8]) * FOLD_W'(MOD_CHUNK[i]);
      end
      recip_w = 61'(fold_ff) * 61'(MOD_RECIP);
      mr_w    = fold_ff - FOLD_W'(mq_ff) * FOLD_W'(TWO_PI_Q16);
      mr_fix  = (mr_ff >= MODR_W'(TWO_PI_Q16)) ? mr_ff - MODR_W'(TWO_PI_Q16) : mr_ff;
   end

   ddo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.cordic_start),
      .angle   (a_ff),
      .done    (cor_done),
      .cos_q16 (cos_q16),
      .sin_q16 (sin_q16)
   );

   // saturating accumulators
   always_comb begin
      sumx    = $signed({{2{accx_ff[ACC_W-1]}}, accx_ff}) + stepx_ff[ACC_W+1:0];
      sumy    = $signed({{2{accy_ff[ACC_W-1]}}, accy_ff}) + stepy_ff[ACC_W+1:0];
      accx_in = accx_ff;
      accy_in = accy_ff;
      if (cmd.acc_upd) begin
         accx_in = (sumx > ACC_HI) ? ACC_HI[ACC_W-1:0] :
                   (sumx < ACC_LO) ? ACC_LO[ACC_W-1:0] : sumx[ACC_W-1:0];
         accy_in = (sumy > ACC_HI) ? ACC_HI[ACC_W-1:0] :
                   (sumy < ACC_LO) ? ACC_LO[ACC_W-1:0] : sumy[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accx_ff <= '0;
         accy_ff <= '0;
      end else begin
         accx_ff <= accx_in;
         accy_ff <= accy_in;
      end
   end

   // compass sector
   always_comb begin
      if (a_ff < Q16_45 || a_ff >= Q16_315) begin
         dir = DIR_NORTH;
      end else if (a_ff < Q16_135) begin
         dir = DIR_WEST;
      end else if (a_ff < Q16_225) begin
         dir = DIR_SOUTH;
      end else begin
         dir = DIR_EAST;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ls_ff <= req_tdata[23:0];
         rs_ff <= req_tdata[47:24];
         ld_ff <= req_tdata[79:48];
         rd_ff <= req_tdata[111:80];
      end
      if (cmd.prod) begin
         fwd_ff   <= sum_sp[24:1];
         prate_ff <= SN_W'(prate_w);
         pang_ff  <= SN_W'(pang_w);
      end
      if (cmd.div_start) begin
         neg_ff <= n_sel[SN_W-1];
      end
      if (cmd.div_take) begin
         case (cmd.op)
            OP_RATE:   rate_ff  <= sat_s32(q_s);
            OP_ANG:    ang_ff   <= q_s;
            OP_STEP_X: stepx_ff <= q_s;
            OP_STEP_Y: stepy_ff <= q_s;
            OP_CELL_X: cellx_ff <= sat_cell(q_s);
            OP_CELL_Y: celly_ff <= sat_cell(q_s);
            default:   rate_ff  <= rate_ff;
         endcase
      end
      if (cmd.mod_fold) begin
         fold_ff <= fold_w;
      end
      if (cmd.mod_mul) begin
         mq_ff <= recip_w[60:49];
      end
      if (cmd.mod_sub) begin
         mr_ff <= mr_w[MODR_W-1:0];
      end
      if (cmd.mod_fix) begin
         a_ff <= (ang_ff[SN_W-1] && mr_fix != '0) ? TWO_PI_Q16 - mr_fix[ANG_W-1:0]
                                                  : mr_fix[ANG_W-1:0];
      end
      if (cmd.step_mul) begin
         pcx_ff <= $signed(fwd_ff) * cos_q16;
         pcy_ff <= $signed(fwd_ff) * sin_q16;
      end
      if (cmd.out_load) begin
         rsp_ff <= {6'd0, fwd_ff, rate_ff, sat_s32(ang_ff), dir, celly_ff, cellx_ff,
                    sat_s32(SN_W'(accy_ff >>> 8)), sat_s32(SN_W'(accx_ff >>> 8))};
      end
   end

   assign sts.div_done    = div_done;
   assign sts.cordic_done = cor_done;
   assign rsp_tdata       = rsp_ff;

endmodule

### hw/rtl/ddo_ctrl.sv
// odometry sequencer: steps the datapath through products, divisions,
// cordic and accumulation; depends on ddo_pkg and the assertion macros
`timescale 1ns / 1ps
`include "differential_drive_odometry_defines.svh"

module ddo_ctrl import ddo_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_PROD;
               op_in    = OP_RATE;
            end
         end
         ST_PROD:      state_in = ST_DIV_GO;
         ST_DIV_GO:    state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               case (op_ff)
                  OP_RATE: begin
                     op_in    = OP_ANG;
                     state_in = ST_DIV_GO;
                  end
                  OP_ANG:    state_in = ST_MOD_FOLD;
                  OP_STEP_X: begin
                     op_in    = OP_STEP_Y;
                     state_in = ST_DIV_GO;
                  end
                  OP_STEP_Y: state_in = ST_ACC;
                  OP_CELL_X: begin
                     op_in    = OP_CELL_Y;
                     state_in = ST_DIV_GO;
                  end
                  OP_CELL_Y: state_in = ST_OUT;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_MOD_FOLD:  state_in = ST_MOD_MUL;
         ST_MOD_MUL:   state_in = ST_MOD_SUB;
         ST_MOD_SUB:   state_in = ST_MOD_FIX;
         ST_MOD_FIX:   state_in = ST_CORDIC_GO;
         ST_CORDIC_GO: state_in = ST_CORDIC_WAIT;
         ST_CORDIC_WAIT: begin
            if (sts.cordic_done) begin
               state_in = ST_STEP_MUL;
            end
         end
         ST_STEP_MUL: begin
            op_in    = OP_STEP_X;
            state_in = ST_DIV_GO;
         end
         ST_ACC: begin
            op_in    = OP_CELL_X;
            state_in = ST_DIV_GO;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd              = '0;
      cmd.op           = op_ff;
      cmd.load         = (state_ff == ST_IDLE) && req_tvalid;
      cmd.prod         = state_ff == ST_PROD;
      cmd.div_start    = state_ff == ST_DIV_GO;
      cmd.div_take     = (state_ff == ST_DIV_WAIT) && sts.div_done;
      cmd.mod_fold     = state_ff == ST_MOD_FOLD;
      cmd.mod_mul      = state_ff == ST_MOD_MUL;
      cmd.mod_sub      = state_ff == ST_MOD_SUB;
      cmd.mod_fix      = state_ff == ST_MOD_FIX;
      cmd.cordic_start = state_ff == ST_CORDIC_GO;
      cmd.step_mul     = state_ff == ST_STEP_MUL;
      cmd.acc_upd      = state_ff == ST_ACC;
      cmd.out_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
      req_tready       = state_ff == ST_IDLE;
      rsp_tvalid       = rsp_valid_ff;
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_RATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DDO_ASSERT_NEXT(a_accept_starts, clock, reset, state_ff == ST_IDLE && req_tvalid,
                    state_ff == ST_PROD, "accepted beat did not start work")
   `DDO_ASSERT_NEXT(a_load_shows, clock, reset, cmd.out_load, rsp_valid_ff,
                    "loaded result not offered")
   `DDO_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_tready,
                   "pending result overwritten")
   `DDO_ASSERT_NEXT(a_div_wait, clock, reset, state_ff == ST_DIV_WAIT && !sts.div_done,
                    state_ff == ST_DIV_WAIT && $stable(op_ff), "left division before done")

endmodule

### hw/rtl/differential_drive_odometry.sv
// Differential-drive odometry. Input beat on req_*: two wheel speeds and two
// cumulative wheel distances. Output beat on rsp_*: position, maze cell,
// compass direction, heading, turn rate and forward speed.
// Configuration on csr_*: index 0 wheel base, 1 cell width, 2 tick rate,
// 3 rotation scale; always ready, write only while the block is idle.
// One result beat per input beat. After the accept, the block runs six
// divisions on one shared restoring divider, a heading wrap (fold,
// multiply, subtract, fix) and a cordic rotation before rsp_tvalid rises.
// A new item is not accepted while one is in progress; the next item can
// be accepted in the cycle after the result is loaded.
// Reset restores the default configuration and zeroes the position.
// When the receiver stalls, the result stays in the output register; the
// next item is accepted and computed, then waits until the pending beat is
// taken. Order is kept and no result is dropped.
// depends on ddo_pkg, ddo_ctrl, ddo_dp
`timescale 1ns / 1ps

module differential_drive_odometry import ddo_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // left_speed[23:0], right_speed[47:24], left_distance[79:48],
   // right_distance[111:80]
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // pos_x[31:0], pos_y[63:32], cell_x[71:64], cell_y[79:72],
   // compass[81:80], heading_angle[113:82], turn_rate[145:114],
   // forward_speed[169:146], zero pad[175:170]
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   ddo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ddo_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule
